// ===== hw/rtl/fba_pkg.sv =====
// Package for the fit block allocator: codes, field widths and default sizes.
// Used by fit_block_allocator_top and its checker; depends on nothing else.
package fba_pkg;

  // Default table depth and capacity width.
  localparam int unsigned MAX_BLOCKS_DEF = 32;
  localparam int unsigned SIZE_BITS_DEF  = 16;

  // Fixed widths of the stream fields.
  localparam int unsigned FUNC_W      = 2;
  localparam int unsigned LOAD_IDX_W  = 5;
  localparam int unsigned FIELD_SZ_W  = 16;
  localparam int unsigned GRANT_BLK_W = 5;
  localparam int unsigned NUM_BLK_W   = 6;
  localparam int unsigned MODE_W      = 2;
  localparam int unsigned S_TDATA_W   = 40;
  localparam int unsigned M_TDATA_W   = 8;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = 6;

  // Function carried in s_axis_tuser.
  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOAD    = 2'd0,
    FUNC_ALLOC   = 2'd1,
    FUNC_RESTART = 2'd2
  } func_e;

  // Search rule.
  typedef enum logic [MODE_W-1:0] {
    MODE_FIRST = 2'd0,
    MODE_BEST  = 2'd1,
    MODE_WORST = 2'd2,
    MODE_NEXT  = 2'd3
  } mode_e;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FIT_MODE   = 1'b0,
    CFG_NUM_BLOCKS = 1'b1
  } cfg_idx_e;

endpackage

// ===== hw/rtl/fit_block_allocator_top.sv =====
// Fit block allocator: capacity table with first, best, worst and next fit search.
// Depends on fba_pkg for codes and widths; holds both capacity memories itself.
//
// Channel   Dir  Handshake               Contents
// s_axis    in   tvalid/tready           tuser: func; tdata: index, load size, request size
// m_axis    out  tvalid/tready           tdata: granted, grant block
// cfg       in   cfg_we_i (no wait)      cfg_index_i selects fit mode or block count
//
// A load request writes the original-capacity memory directly. An allocate scans n entries,
// where n is the clipped block count: one read of the remaining-capacity memory per cycle
// through one comparator. A restart copies all MAX_BLOCKS entries, one memory copy per cycle.
// Reset clears the control state and the next-fit pointer; the memories are not cleared.
// A result waits in the output register; a second allocate stalls at its end while it waits.
module fit_block_allocator_top #(
  parameter int unsigned MAX_BLOCKS = fba_pkg::MAX_BLOCKS_DEF,
  parameter int unsigned SIZE_BITS  = fba_pkg::SIZE_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Input requests.
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // From bit 0: load_index[4:0], load_size[20:5], request_size[36:21], zero pad.
  input  logic [fba_pkg::S_TDATA_W-1:0]    s_axis_tdata,
  // From bit 0: func[1:0].
  input  logic [fba_pkg::FUNC_W-1:0]       s_axis_tuser,
  // Results.
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // From bit 0: granted[0], grant_block[5:1], zero pad.
  output logic [fba_pkg::M_TDATA_W-1:0]    m_axis_tdata,
  // Configuration writes.
  input  logic                             cfg_we_i,
  input  logic [fba_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [fba_pkg::CFG_DATA_W-1:0]   cfg_wdata_i
);

  localparam int unsigned IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_BLOCKS + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COPY,
    ST_DONE
  } state_e;

  // Request fields.
  logic [fba_pkg::LOAD_IDX_W-1:0] in_load_index;
  logic [fba_pkg::FIELD_SZ_W-1:0] in_load_size;
  logic [fba_pkg::FIELD_SZ_W-1:0] in_request_size;
  logic                           in_accept;

  assign in_load_index   = s_axis_tdata[4:0];
  assign in_load_size    = s_axis_tdata[20:5];
  assign in_request_size = s_axis_tdata[36:21];
  assign in_accept       = s_axis_tvalid && s_axis_tready;

  // Configuration.
  fba_pkg::mode_e                mode_q;
  logic [fba_pkg::NUM_BLK_W-1:0] nb_q;

  // Sequencer and scan datapath.
  state_e               state_q, state_d;
  logic [CNT_W-1:0]     lim_q, lim_d;
  logic [CNT_W-1:0]     left_q, left_d;
  logic [IDX_W-1:0]     cur_q, cur_d;
  logic                 ev_v_q, ev_v_d;
  logic [IDX_W-1:0]     ev_idx_q, ev_idx_d;
  logic [SIZE_BITS-1:0] req_q, req_d;
  logic                 found_q, found_d;
  logic [IDX_W-1:0]     pick_q, pick_d;
  logic [SIZE_BITS-1:0] best_q, best_d;
  logic [IDX_W-1:0]     ptr_q, ptr_d;
  logic                 out_v_q, out_v_d;
  logic                 out_granted_q, out_granted_d;
  logic [fba_pkg::GRANT_BLK_W-1:0] out_block_q, out_block_d;

  logic [CNT_W-1:0]     n_clip;
  logic [IDX_W-1:0]     cur_next;
  logic [IDX_W-1:0]     scan_start;
  logic                 fits;
  logic                 better;

  // Memory ports.
  logic [SIZE_BITS-1:0] orig_mem [MAX_BLOCKS];
  logic [SIZE_BITS-1:0] rem_mem  [MAX_BLOCKS];
  logic [SIZE_BITS-1:0] orig_rd_q;
  logic [SIZE_BITS-1:0] rem_rd_q;
  logic                 orig_we;
  logic                 rem_we;
  logic [IDX_W-1:0]     rem_wa;
  logic [SIZE_BITS-1:0] rem_wd;

  assign n_clip = (32'(nb_q) > MAX_BLOCKS) ? CNT_W'(MAX_BLOCKS) : CNT_W'(nb_q);

  assign cur_next = ((CNT_W'(cur_q) + CNT_W'(1)) == lim_q) ? '0 : cur_q + IDX_W'(1);

  assign scan_start = ((mode_q == fba_pkg::MODE_NEXT) && (CNT_W'(ptr_q) < n_clip)) ?
                      ptr_q : '0;

  // The shared comparator pair: fit against the request, and against the best so far.
  assign fits   = (rem_rd_q >= req_q);
  assign better = ((mode_q == fba_pkg::MODE_BEST)  && (rem_rd_q < best_q)) ||
                  ((mode_q == fba_pkg::MODE_WORST) && (rem_rd_q > best_q));

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {2'b00, out_block_q, out_granted_q};

  assign orig_we = in_accept && (fba_pkg::func_e'(s_axis_tuser) == fba_pkg::FUNC_LOAD) &&
                   (32'(in_load_index) < MAX_BLOCKS);

  always_comb begin
    state_d       = state_q;
    lim_d         = lim_q;
    left_d        = left_q;
    cur_d         = cur_q;
    ev_v_d        = 1'b0;
    ev_idx_d      = cur_q;
    req_d         = req_q;
    found_d       = found_q;
    pick_d        = pick_q;
    best_d        = best_q;
    ptr_d         = ptr_q;
    out_v_d       = out_v_q && !m_axis_tready;
    out_granted_d = out_granted_q;
    out_block_d   = out_block_q;
    rem_we        = 1'b0;
    rem_wa        = ev_idx_q;
    rem_wd        = orig_rd_q;

    // Issue one memory read per cycle while entries remain.
    if ((state_q == ST_SCAN || state_q == ST_COPY) && left_q != '0) begin
      ev_v_d = 1'b1;
      cur_d  = cur_next;
      left_d = left_q - CNT_W'(1);
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          case (fba_pkg::func_e'(s_axis_tuser))
            fba_pkg::FUNC_ALLOC: begin
              cur_d   = scan_start;
              lim_d   = n_clip;
              left_d  = n_clip;
              req_d   = SIZE_BITS'(in_request_size);
              found_d = 1'b0;
              state_d = ST_SCAN;
            end
            fba_pkg::FUNC_RESTART: begin
              cur_d   = '0;
              lim_d   = CNT_W'(MAX_BLOCKS);
              left_d  = CNT_W'(MAX_BLOCKS);
              ptr_d   = '0;
              state_d = ST_COPY;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        if (ev_v_q && fits && (!found_q || better)) begin
          found_d = 1'b1;
          pick_d  = ev_idx_q;
          best_d  = rem_rd_q;
        end
        if (left_q == '0 && !ev_v_q) begin
          state_d = ST_DONE;
        end
      end
      ST_COPY: begin
        rem_we = ev_v_q;
        if (left_q == '0 && !ev_v_q) begin
          state_d = ST_IDLE;
        end
      end
      ST_DONE: begin
        if (!out_v_q || m_axis_tready) begin
          rem_we        = found_q;
          rem_wa        = pick_q;
          rem_wd        = best_q - req_q;
          out_v_d       = 1'b1;
          out_granted_d = found_q;
          out_block_d   = found_q ? fba_pkg::GRANT_BLK_W'(pick_q) : '0;
          if (found_q && mode_q == fba_pkg::MODE_NEXT) begin
            ptr_d = pick_q;
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      mode_q        <= fba_pkg::MODE_FIRST;
      nb_q          <= '0;
      lim_q         <= '0;
      left_q        <= '0;
      cur_q         <= '0;
      ev_v_q        <= 1'b0;
      ev_idx_q      <= '0;
      req_q         <= '0;
      found_q       <= 1'b0;
      pick_q        <= '0;
      best_q        <= '0;
      ptr_q         <= '0;
      out_v_q       <= 1'b0;
      out_granted_q <= 1'b0;
      out_block_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (fba_pkg::cfg_idx_e'(cfg_index_i))
          fba_pkg::CFG_FIT_MODE:   mode_q <= fba_pkg::mode_e'(cfg_wdata_i[1:0]);
          fba_pkg::CFG_NUM_BLOCKS: nb_q   <= cfg_wdata_i;
          default: ;
        endcase
      end
      state_q       <= state_d;
      lim_q         <= lim_d;
      left_q        <= left_d;
      cur_q         <= cur_d;
      ev_v_q        <= ev_v_d;
      ev_idx_q      <= ev_idx_d;
      req_q         <= req_d;
      found_q       <= found_d;
      pick_q        <= pick_d;
      best_q        <= best_d;
      ptr_q         <= ptr_d;
      out_v_q       <= out_v_d;
      out_granted_q <= out_granted_d;
      out_block_q   <= out_block_d;
    end
  end

  // Original capacities: written by loads, read by the restart copy.
  always_ff @(posedge clk_i) begin
    if (orig_we) begin
      orig_mem[IDX_W'(in_load_index)] <= SIZE_BITS'(in_load_size);
    end
    orig_rd_q <= orig_mem[cur_q];
  end

  // Remaining capacities: written by the copy and by a grant, read by the scan.
  always_ff @(posedge clk_i) begin
    if (rem_we) begin
      rem_mem[rem_wa] <= rem_wd;
    end
    rem_rd_q <= rem_mem[cur_q];
  end

endmodule

// ===== hw/rtl/fba_checker.sv =====
// Port-level checker for fit_block_allocator_top, with the bind that attaches it.
// Depends on fba_pkg for the function codes and stream widths.
module fba_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic [fba_pkg::FUNC_W-1:0]       s_axis_tuser,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [fba_pkg::M_TDATA_W-1:0]    m_axis_tdata
);

  // An allocate request always runs a scan, so the input is busy on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser == fba_pkg::FUNC_ALLOC)
    |=> !s_axis_tready)
    else $error("input ready straight after an allocate request");

  // A restart copies the whole table, so the input is busy on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser == fba_pkg::FUNC_RESTART)
    |=> !s_axis_tready)
    else $error("input ready straight after a restart request");

  // A refusal carries block zero and a clean pad.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tdata[0]) |-> (m_axis_tdata[7:1] == 7'd0))
    else $error("refused result with non-zero block field");

  // A stalled result holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("result changed or dropped while stalled");

endmodule

bind fit_block_allocator_top fba_checker u_fba_checker (.*);
